FILE: design/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared types, character codes and tables of the tool-path line parser.
// ----------------------------------------------------------------------------
package tlp_pkg;

  // text bytes that steer the parser
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // highest move type that is accepted
  localparam logic [3:0] MAX_TYPE = 4'd2;

  typedef enum logic [3:0] {
    PH_START,
    PH_LINENO,
    PH_TYPE1,
    PH_TYPE2,
    PH_LETTER,
    PH_SIGN,
    PH_NUMBER,
    PH_TAIL,
    PH_DONE,
    PH_IGNORE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_FAST,
    ST_MILL,
    ST_BADTYPE,
    ST_EMPTY,
    ST_OVERFLOW
  } status_e;

  // outcome of one digit step of the number accumulator
  typedef struct packed {
    logic push;
    logic frac_inc;
    logic ovf;
  } num_step_t;

  // result control handed from the parser to the output register
  typedef struct packed {
    logic    vld;
    status_e status;
  } res_ctl_t;

  // powers of ten for the fixed point scaling
  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] p;
    unique case (e)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: design/tlp_ch_if.sv
// ----------------------------------------------------------------------------
// tlp_ch_if
// Character channel: one text byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlp_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

FILE: design/tlp_res_if.sv
// ----------------------------------------------------------------------------
// tlp_res_if
// Result channel: move status and three coordinates, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlp_res_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  tlp_pkg::status_e             status;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, output status, output coord_x, output coord_y,
                  output coord_z, input ready);
  modport sink   (input valid, input status, input coord_x, input coord_y,
                  input coord_z, output ready);
endinterface

FILE: design/tlp_num.sv
// ----------------------------------------------------------------------------
// tlp_num
// One digit step of the coordinate accumulator. The magnitude is kept
// already scaled to full fixed point, so no padding is needed at the end.
// ----------------------------------------------------------------------------
module tlp_num #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic [COORD_BITS-1:0]              mag_i,
  input  logic                               neg_i,
  input  logic                               dot_i,
  input  logic [$clog2(FRAC_DIGITS+1)-1:0]   frac_i,
  input  logic [3:0]                         digit_i,
  output logic [COORD_BITS-1:0]              mag_o,
  output tlp_pkg::num_step_t                 step_o
);
  import tlp_pkg::*;

  localparam int unsigned CW = COORD_BITS + 28;
  localparam int unsigned FW = $clog2(FRAC_DIGITS + 1);

  logic [CW-1:0] mag_w;
  logic [CW-1:0] sum_w;
  logic [CW-1:0] limit_w;
  logic [27:0]   scale_w;
  logic [2:0]    exp_w;
  logic          frac_open;
  logic          push;

  assign frac_open = (frac_i < FW'(FRAC_DIGITS));
  assign mag_w     = CW'(mag_i);

  // integer digit lands at 10^F, fraction digit f at 10^(F-1-f)
  assign exp_w   = dot_i ? (3'(FRAC_DIGITS - 1) - 3'(frac_i)) : 3'(FRAC_DIGITS);
  assign scale_w = 28'(digit_i) * 28'(pow10(exp_w));

  assign sum_w = dot_i ? (mag_w + CW'(scale_w))
                       : ((mag_w << 3) + (mag_w << 1) + CW'(scale_w));

  // negative side may reach 2^(B-1), positive side one less
  assign limit_w = neg_i ? (CW'(1) << (COORD_BITS - 1))
                         : ((CW'(1) << (COORD_BITS - 1)) - CW'(1));

  assign push = !dot_i || frac_open;

  assign step_o.push     = push;
  assign step_o.frac_inc = dot_i && frac_open;
  assign step_o.ovf      = push && (sum_w > limit_w);
  assign mag_o           = push ? sum_w[COORD_BITS-1:0] : mag_i;

endmodule

FILE: design/tlp_parse.sv
// ----------------------------------------------------------------------------
// tlp_parse
// Line state machine: walks one character per step through line number,
// move type and three coordinates and forms the result at each newline.
// ----------------------------------------------------------------------------
module tlp_parse #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             ch_i,
  output tlp_pkg::res_ctl_t      res_ctl_o,
  output logic [COORD_BITS-1:0]  cx_o,
  output logic [COORD_BITS-1:0]  cy_o,
  output logic [COORD_BITS-1:0]  cz_o
);
  import tlp_pkg::*;

  localparam int unsigned FW = $clog2(FRAC_DIGITS + 1);

  phase_e                phase_q, phase_d;
  status_e               err_q, err_d, err_set;
  logic [1:0]            idx_q, idx_d;
  logic                  typez_q, typez_d;
  logic                  mill_q, mill_d;
  logic                  neg_q, neg_d;
  logic                  dot_q, dot_d;
  logic                  seen_q, seen_d;
  logic [FW-1:0]         frac_q, frac_d;
  logic [COORD_BITS-1:0] mag_q, mag_d;
  logic [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

  logic                  is_nl, is_dig, is_dot, is_minus;
  logic [3:0]            dig;
  logic [COORD_BITS-1:0] mag_n;
  logic [COORD_BITS-1:0] sval;
  num_step_t             nstep;
  phase_e                fin_phase;

  assign is_nl    = (ch_i == CH_NL);
  assign is_dig   = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_dot   = (ch_i == CH_DOT);
  assign is_minus = (ch_i == CH_MINUS);
  assign dig      = 4'(ch_i - CH_ZERO);

  assign sval = neg_q ? (~mag_q + COORD_BITS'(1)) : mag_q;

  // where a number ends up when it is closed
  assign fin_phase = !seen_q ? PH_ERROR : ((idx_q == 2'd2) ? PH_DONE : PH_SIGN);

  tlp_num #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_num (
    .mag_i   (mag_q),
    .neg_i   (neg_q),
    .dot_i   (dot_q),
    .frac_i  (frac_q),
    .digit_i (dig),
    .mag_o   (mag_n),
    .step_o  (nstep)
  );

  // next phase and the error code raised on entering the error phase
  always_comb begin
    phase_d = phase_q;
    err_set = ST_EMPTY;
    if (is_nl) begin
      phase_d = PH_START;
    end else begin
      unique case (phase_q)
        PH_START:  phase_d = (ch_i == CH_N) ? PH_LINENO : PH_IGNORE;
        PH_LINENO: begin
          if (ch_i == CH_G) begin
            phase_d = PH_TYPE1;
          end else if (!is_dig) begin
            phase_d = PH_IGNORE;
          end
        end
        PH_TYPE1: begin
          err_set = ST_BADTYPE;
          phase_d = is_dig ? PH_TYPE2 : PH_ERROR;
        end
        PH_TYPE2: begin
          err_set = ST_BADTYPE;
          phase_d = (is_dig && typez_q && (dig <= MAX_TYPE)) ? PH_LETTER : PH_ERROR;
        end
        PH_LETTER: phase_d = PH_SIGN;
        PH_SIGN, PH_NUMBER: begin
          if (is_minus && (phase_q == PH_SIGN)) begin
            phase_d = PH_NUMBER;
          end else if (is_dig) begin
            err_set = ST_OVERFLOW;
            phase_d = nstep.ovf ? PH_ERROR : PH_NUMBER;
          end else if (is_dot) begin
            phase_d = dot_q ? PH_TAIL : PH_NUMBER;
          end else begin
            phase_d = fin_phase;
          end
        end
        PH_TAIL: begin
          if (!is_dig && !is_dot) begin
            phase_d = fin_phase;
          end
        end
        PH_DONE, PH_IGNORE, PH_ERROR: phase_d = phase_q;
        default: phase_d = PH_IGNORE;
      endcase
    end
  end

  assign err_d = (step_i && !is_nl && (phase_d == PH_ERROR) && (phase_q != PH_ERROR))
                 ? err_set : (is_nl ? ST_FAST : err_q);

  // number and coordinate registers
  always_comb begin
    idx_d   = idx_q;
    typez_d = typez_q;
    mill_d  = mill_q;
    neg_d   = neg_q;
    dot_d   = dot_q;
    seen_d  = seen_q;
    frac_d  = frac_q;
    mag_d   = mag_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    if (is_nl) begin
      idx_d   = 2'd0;
      typez_d = 1'b0;
      mill_d  = 1'b0;
      neg_d   = 1'b0;
      dot_d   = 1'b0;
      seen_d  = 1'b0;
      frac_d  = '0;
      mag_d   = '0;
    end else begin
      unique case (phase_q)
        PH_TYPE1: typez_d = (dig == 4'd0);
        PH_TYPE2: begin
          mill_d = (dig != 4'd0);
          idx_d  = 2'd0;
        end
        PH_SIGN, PH_NUMBER, PH_TAIL: begin
          if (is_minus && (phase_q == PH_SIGN)) begin
            neg_d = 1'b1;
          end else if (is_dig) begin
            if (phase_q != PH_TAIL) begin
              seen_d = 1'b1;
              mag_d  = mag_n;
              if (nstep.frac_inc) begin
                frac_d = frac_q + FW'(1);
              end
            end
          end else if (is_dot) begin
            if (phase_q != PH_TAIL) begin
              dot_d = 1'b1;
            end
          end else if (seen_q) begin
            // number closed: store it and start the next one
            unique case (idx_q)
              2'd0:    cx_d = sval;
              2'd1:    cy_d = sval;
              default: cz_d = sval;
            endcase
            if (idx_q != 2'd2) begin
              idx_d = idx_q + 2'd1;
            end
            neg_d  = 1'b0;
            dot_d  = 1'b0;
            seen_d = 1'b0;
            frac_d = '0;
            mag_d  = '0;
          end
        end
        default: idx_d = idx_q;
      endcase
    end
  end

  // result formed at a newline
  always_comb begin
    res_ctl_o.vld    = 1'b0;
    res_ctl_o.status = ST_FAST;
    cx_o             = '0;
    cy_o             = '0;
    cz_o             = '0;
    if (is_nl) begin
      unique case (phase_q)
        PH_TYPE1, PH_TYPE2: begin
          res_ctl_o.vld    = 1'b1;
          res_ctl_o.status = ST_BADTYPE;
        end
        PH_LETTER, PH_SIGN: begin
          res_ctl_o.vld    = 1'b1;
          res_ctl_o.status = ST_EMPTY;
        end
        PH_NUMBER, PH_TAIL: begin
          res_ctl_o.vld = 1'b1;
          if (!seen_q || (idx_q != 2'd2)) begin
            res_ctl_o.status = ST_EMPTY;
          end else begin
            res_ctl_o.status = mill_q ? ST_MILL : ST_FAST;
            cx_o             = cx_q;
            cy_o             = cy_q;
            cz_o             = sval;
          end
        end
        PH_DONE: begin
          res_ctl_o.vld    = 1'b1;
          res_ctl_o.status = mill_q ? ST_MILL : ST_FAST;
          cx_o             = cx_q;
          cy_o             = cy_q;
          cz_o             = cz_q;
        end
        PH_ERROR: begin
          res_ctl_o.vld    = 1'b1;
          res_ctl_o.status = err_q;
        end
        default: res_ctl_o.vld = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      err_q   <= ST_FAST;
      idx_q   <= 2'd0;
      typez_q <= 1'b0;
      mill_q  <= 1'b0;
      neg_q   <= 1'b0;
      dot_q   <= 1'b0;
      seen_q  <= 1'b0;
      frac_q  <= '0;
      mag_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      idx_q   <= idx_d;
      typez_q <= typez_d;
      mill_q  <= mill_d;
      neg_q   <= neg_d;
      dot_q   <= dot_d;
      seen_q  <= seen_d;
      frac_q  <= frac_d;
      mag_q   <= mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

endmodule

FILE: design/toolpath_line_parser.sv
// ----------------------------------------------------------------------------
// toolpath_line_parser
// Parses tool-path text lines N<digits>G<type><l><num><l><num><l><num> into
// move results with three fixed point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   chr_i takes one text byte per item; byte 10 ends a line. res_o gives one
//   item per parsed line at its newline: status (fast move, milling move,
//   bad type, empty number, overflow) and the three coordinates in units of
//   10^-FRAC_DIGITS, zero on any error status. Lines that do not start with
//   N, or have no G after the line number digits, give no item.
//   A byte is taken into an input register, walked through the line state
//   machine and the result is loaded into the output register on res_o.
//   One byte per cycle is sustained while no newline waits on a full output;
//   the cycle is set by the digit step of the coordinate accumulator
//   (magnitude times ten plus a scaled digit and the range compare).
//   When res_o is stalled with a result waiting, bytes that cause no result
//   still flow; the parser holds only on a newline that needs the output.
//   Reset clears both valid flags and the parser returns to line start.
// ----------------------------------------------------------------------------
module toolpath_line_parser #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlp_ch_if.sink     chr_i,
  tlp_res_if.source  res_o
);
  import tlp_pkg::*;

  logic                  ch_vld_q, ch_vld_d;
  logic [7:0]            ch_q;
  logic                  out_vld_q, out_vld_d;
  status_e               status_q;
  logic [COORD_BITS-1:0] cx_q, cy_q, cz_q;
  logic                  go;
  res_ctl_t              res_ctl;
  logic [COORD_BITS-1:0] cx, cy, cz;

  // a byte moves on unless it makes a result and the output is still full
  assign go = ch_vld_q && !(res_ctl.vld && out_vld_q && !res_o.ready);

  assign chr_i.ready = !ch_vld_q || go;

  assign ch_vld_d  = (chr_i.valid && chr_i.ready) ? 1'b1 : (go ? 1'b0 : ch_vld_q);
  assign out_vld_d = (go && res_ctl.vld) ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  tlp_parse #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (go),
    .ch_i      (ch_q),
    .res_ctl_o (res_ctl),
    .cx_o      (cx),
    .cy_o      (cy),
    .cz_o      (cz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ch_vld_q  <= ch_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_i.valid && chr_i.ready) begin
      ch_q <= chr_i.ch;
    end
    if (go && res_ctl.vld) begin
      status_q <= res_ctl.status;
      cx_q     <= cx;
      cy_q     <= cy;
      cz_q     <= cz;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.status  = status_q;
  assign res_o.coord_x = $signed(cx_q);
  assign res_o.coord_y = $signed(cy_q);
  assign res_o.coord_z = $signed(cz_q);

  // a buffered byte that cannot move keeps its value
  a_ch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_vld_q && !go |=> ch_vld_q && $stable(ch_q))
    else $error("buffered byte lost or changed while held");

  // a result produced by the parser shows up on the output next cycle
  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res_ctl.vld |=> res_o.valid)
    else $error("parsed result not presented");

  // error results carry zero coordinates
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != ST_FAST) && (res_o.status != ST_MILL)
    |-> (cx_q == '0) && (cy_q == '0) && (cz_q == '0))
    else $error("error result with nonzero coordinates");

endmodule
